### hw/rtl/cau_pkg.sv
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // derived widths
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int NUM_W      = PROD_W + 1;
  localparam int SHN_W      = PROD_W + FRAC_BITS;
  localparam int QUO_W      = DATA_WIDTH + 1;
  localparam int DIV_STAGES = QUO_W;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic [1:0] cmd;
    data_t      a_re;
    data_t      a_im;
    data_t      b_re;
    data_t      b_im;
  } op_t;

  // one quotient lane: partial remainder, numerator bits shifting out, quotient in
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  nq;
    logic              neg;
    logic              ovf;
  } lane_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              dz;
    data_t             fast_re;
    data_t             fast_im;
    logic [1:0]        fast_status;
    logic [PROD_W-1:0] den;
    lane_t             re;
    lane_t             im;
  } pipe_t;

  typedef struct packed {
    data_t val;
    logic  clamped;
  } sat_t;

  // clamp a wide signed value to the data range
  function automatic sat_t sat_wide(input logic signed [NUM_W-1:0] v);
    sat_t r;
    logic signed [NUM_W-1:0] hi;
    logic signed [NUM_W-1:0] lo;
    hi = {{(NUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r.val = hi[DATA_WIDTH-1:0];
      r.clamped = 1'b1;
    end else if (v < lo) begin
      r.val = lo[DATA_WIDTH-1:0];
      r.clamped = 1'b1;
    end else begin
      r.val = v[DATA_WIDTH-1:0];
      r.clamped = 1'b0;
    end
    return r;
  endfunction

endpackage

### hw/rtl/cau_if.sv
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  cau_pkg::data_t     a_re;
  cau_pkg::data_t     a_im;
  cau_pkg::data_t     b_re;
  cau_pkg::data_t     b_im;

  modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  cau_pkg::data_t     res_re;
  cau_pkg::data_t     res_im;
  logic [1:0]         status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

### hw/rtl/cau_front.sv
module cau_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  cau_pkg::op_t    op,
  output logic            out_valid,
  output cau_pkg::pipe_t  out_pipe
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PROD_W;
  localparam int NW = cau_pkg::NUM_W;
  localparam int SW = cau_pkg::SHN_W;
  localparam int QW = cau_pkg::QUO_W;

  // stage 1: products and sums
  logic                 v1;
  logic [1:0]           cmd1;
  logic                 dz1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [DW:0]   s_re, s_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      cmd1 <= op.cmd;
      dz1  <= (op.b_re == '0) && (op.b_im == '0);
      p_rr <= PW'(op.a_re) * PW'(op.b_re);
      p_ii <= PW'(op.a_im) * PW'(op.b_im);
      p_ri <= PW'(op.a_re) * PW'(op.b_im);
      p_ir <= PW'(op.a_im) * PW'(op.b_re);
      p_bb <= PW'(op.b_re) * PW'(op.b_re);
      p_cc <= PW'(op.b_im) * PW'(op.b_im);
      if (op.cmd == cau_pkg::CMD_SUB) begin
        s_re <= {op.a_re[DW-1], op.a_re} - {op.b_re[DW-1], op.b_re};
        s_im <= {op.a_im[DW-1], op.a_im} - {op.b_im[DW-1], op.b_im};
      end else begin
        s_re <= {op.a_re[DW-1], op.a_re} + {op.b_re[DW-1], op.b_re};
        s_im <= {op.a_im[DW-1], op.a_im} + {op.b_im[DW-1], op.b_im};
      end
    end
  end

  // stage 2: combine products
  logic                 v2;
  logic [1:0]           cmd2;
  logic                 dz2;
  logic signed [NW-1:0] w_re, w_im, n_re, n_im;
  logic [PW-1:0]        den2;
  logic signed [NW-1:0] m_re, m_im;

  always_comb begin
    m_re = {p_rr[PW-1], p_rr} - {p_ii[PW-1], p_ii};
    m_im = {p_ri[PW-1], p_ri} + {p_ir[PW-1], p_ir};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      cmd2 <= cmd1;
      dz2  <= dz1;
      n_re <= {p_rr[PW-1], p_rr} + {p_ii[PW-1], p_ii};
      n_im <= {p_ir[PW-1], p_ir} - {p_ri[PW-1], p_ri};
      den2 <= $unsigned(p_bb) + $unsigned(p_cc);
      if (cmd1 == cau_pkg::CMD_MUL) begin
        w_re <= m_re >>> cau_pkg::FRAC_BITS;
        w_im <= m_im >>> cau_pkg::FRAC_BITS;
      end else begin
        w_re <= {{(NW-DW-1){s_re[DW]}}, s_re};
        w_im <= {{(NW-DW-1){s_im[DW]}}, s_im};
      end
    end
  end

  // stage 3: saturate the direct results, take numerator magnitudes
  logic                 v3;
  logic [1:0]           cmd3;
  logic                 dz3;
  cau_pkg::data_t       f_re, f_im;
  logic [1:0]           f_st;
  logic [PW-1:0]        den3;
  logic [PW-1:0]        mag_re, mag_im;
  logic                 neg_re, neg_im;
  cau_pkg::sat_t        sr, si;
  logic signed [NW-1:0] ab_re, ab_im;

  always_comb begin
    sr = cau_pkg::sat_wide(w_re);
    si = cau_pkg::sat_wide(w_im);
    ab_re = n_re[NW-1] ? -n_re : n_re;
    ab_im = n_im[NW-1] ? -n_im : n_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      cmd3   <= cmd2;
      dz3    <= dz2;
      den3   <= den2;
      neg_re <= n_re[NW-1];
      neg_im <= n_im[NW-1];
      mag_re <= ab_re[PW-1:0];
      mag_im <= ab_im[PW-1:0];
      if ((cmd2 == cau_pkg::CMD_DIV) && dz2) begin
        f_re <= '0;
        f_im <= '0;
        f_st <= cau_pkg::ST_DIV0;
      end else begin
        f_re <= sr.val;
        f_im <= si.val;
        f_st <= (sr.clamped || si.clamped) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  // stage 4: scale numerators, detect quotient overflow, seed the divider
  logic [SW-1:0] sh_re, sh_im;
  logic [PW-1:0] top_re, top_im;

  always_comb begin
    sh_re  = {mag_re, {cau_pkg::FRAC_BITS{1'b0}}};
    sh_im  = {mag_im, {cau_pkg::FRAC_BITS{1'b0}}};
    top_re = PW'(sh_re[SW-1:QW]);
    top_im = PW'(sh_im[SW-1:QW]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      out_pipe.cmd         <= cmd3;
      out_pipe.dz          <= dz3;
      out_pipe.fast_re     <= f_re;
      out_pipe.fast_im     <= f_im;
      out_pipe.fast_status <= f_st;
      out_pipe.den         <= den3;
      out_pipe.re.rem      <= top_re;
      out_pipe.re.nq       <= sh_re[QW-1:0];
      out_pipe.re.neg      <= neg_re;
      out_pipe.re.ovf      <= top_re >= den3;
      out_pipe.im.rem      <= top_im;
      out_pipe.im.nq       <= sh_im[QW-1:0];
      out_pipe.im.neg      <= neg_im;
      out_pipe.im.ovf      <= top_im >= den3;
    end
  end

endmodule

### hw/rtl/cau_div_stage.sv
module cau_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  cau_pkg::pipe_t  in_pipe,
  output logic            out_valid,
  output cau_pkg::pipe_t  out_pipe
);

  localparam int PW = cau_pkg::PROD_W;
  localparam int QW = cau_pkg::QUO_W;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [PW-1:0] den);
    cau_pkg::lane_t r;
    logic [PW:0] rs;
    logic        fit;
    rs  = {l.rem, l.nq[QW-1]};
    fit = rs >= {1'b0, den};
    r   = l;
    r.rem = fit ? PW'(rs - {1'b0, den}) : rs[PW-1:0];
    r.nq  = {l.nq[QW-2:0], fit};
    return r;
  endfunction

  cau_pkg::pipe_t nxt;

  always_comb begin
    nxt    = in_pipe;
    nxt.re = step(in_pipe.re, in_pipe.den);
    nxt.im = step(in_pipe.im, in_pipe.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_pipe <= nxt;
    end
  end

endmodule

### hw/rtl/complex_arithmetic_unit.sv
// Complex ALU on signed Q15.16 operands: add, subtract, multiply and divide
// (conjugate form, quotient truncated toward zero), saturated results with a
// status of ok, divide by zero or saturated. Every command goes through the
// same 38-stage pipeline: four stages of multipliers, sums and scaling, 33
// restoring divider stages (one quotient bit each, plus an overflow check up
// front), and the output register. It takes one request per cycle while the
// output is not stalled; a stall at the output freezes the whole pipeline.
module complex_arithmetic_unit (
  input  logic       clk,
  input  logic       rst,
  cau_in_if.sink     operands,
  cau_out_if.source  results
);

  localparam int NS = cau_pkg::DIV_STAGES;
  localparam int NW = cau_pkg::NUM_W;
  localparam int QW = cau_pkg::QUO_W;

  logic           en;
  cau_pkg::op_t   op;
  logic           cv [0:NS];
  cau_pkg::pipe_t cp [0:NS];

  // advance whenever the output slot is empty or being taken
  assign en = !results.valid || results.ready;
  assign operands.ready = en;

  always_comb begin
    op.cmd  = operands.command;
    op.a_re = operands.a_re;
    op.a_im = operands.a_im;
    op.b_re = operands.b_re;
    op.b_im = operands.b_im;
  end

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (operands.valid),
    .op        (op),
    .out_valid (cv[0]),
    .out_pipe  (cp[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_div
    cau_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[g]),
      .in_pipe   (cp[g]),
      .out_valid (cv[g+1]),
      .out_pipe  (cp[g+1])
    );
  end

  // apply the sign to a quotient lane and clamp
  function automatic cau_pkg::sat_t finish(input cau_pkg::lane_t l);
    cau_pkg::sat_t r;
    logic signed [NW-1:0] q;
    q = {{(NW-QW){1'b0}}, l.nq};
    if (l.neg) begin
      q = -q;
    end
    r = cau_pkg::sat_wide(q);
    if (l.ovf) begin
      r.clamped = 1'b1;
      r.val = l.neg ? {1'b1, {(cau_pkg::DATA_WIDTH-1){1'b0}}}
                    : {1'b0, {(cau_pkg::DATA_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  cau_pkg::sat_t qr, qi;
  cau_pkg::pipe_t lp;

  always_comb begin
    lp = cp[NS];
    qr = finish(lp.re);
    qi = finish(lp.im);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= cv[NS];
    end
    if (en) begin
      if ((lp.cmd == cau_pkg::CMD_DIV) && !lp.dz) begin
        results.res_re <= qr.val;
        results.res_im <= qi.val;
        results.status <= (qr.clamped || qi.clamped) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else begin
        results.res_re <= lp.fast_re;
        results.res_im <= lp.fast_im;
        results.status <= lp.fast_status;
      end
    end
  end

endmodule
